// ===== rtl/csss_pkg.sv =====
// ----------------------------------------------------------------------------
// csss_pkg
// Shared types, constants and the case fold for the substring search block.
// ----------------------------------------------------------------------------
package csss_pkg;

  localparam int MAX_NEEDLE_DEF   = 32;
  localparam int MAX_HAYSTACK_DEF = 65536;

  // needle bytes held in configuration
  localparam int NEEDLE_REG_BYTES = 32;
  localparam int CFG_IDX_W        = 3;
  localparam int CFG_DATA_W       = 64;
  localparam int LEN_REG_W        = 6;
  localparam int POS_W            = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAT_LEN      = 3'd0,
    CFG_NEEDLE_0_7   = 3'd1,
    CFG_NEEDLE_8_15  = 3'd2,
    CFG_NEEDLE_16_23 = 3'd3,
    CFG_NEEDLE_24_31 = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic shift;   // transfer accepted, move the window on
    logic active;  // cell lies inside the needle length
  } cell_ctl_t;

  // only 'A'..'Z' are folded to lower case
  function automatic logic [7:0] fold_byte(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b >= 8'h41 && b <= 8'h5A) begin
      r = b + 8'h20;
    end
    return r;
  endfunction

endpackage

// ===== rtl/case_insensitive_substring_search.sv =====
// ----------------------------------------------------------------------------
// case_insensitive_substring_search
// First-occurrence case-insensitive needle search over a byte stream.
// ----------------------------------------------------------------------------
// channel  dir  handshake          payload
// s_*      in   s_tvalid/s_tready  tdata: hay_byte; tlast: last
// m_*      out  m_tvalid/m_tready  tdata: found, match_pos
// cfg_*    in   cfg_we             cfg_index, cfg_data
//
// one haystack byte per cycle while s_tready is high; the row of window
// cells compares every position in parallel, so the rate is set by that compare.
// a result appears on m_* in the cycle after the byte that caused it.
// a stalled result holds in the output register; input is taken while the
// output register is empty or being drained. reset is synchronous, no sweep.
// ----------------------------------------------------------------------------
module case_insensitive_substring_search #(
  parameter int MaxNeedle   = csss_pkg::MAX_NEEDLE_DEF,
  parameter int MaxHaystack = csss_pkg::MAX_HAYSTACK_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [7:0]                       s_tdata,   // [7:0] hay_byte
  input  logic                             s_tlast,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [23:0]                      m_tdata,   // [0] found, [16:1] match_pos
  input  logic                             cfg_we,
  input  logic [csss_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [csss_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import csss_pkg::*;

  localparam int LenW = $clog2(MaxNeedle+1);
  localparam int CntW = $clog2(MaxHaystack+1);

  logic [LEN_REG_W-1:0]          pat_len;
  logic [NEEDLE_REG_BYTES*8-1:0] needle_flat;
  logic [LenW-1:0]               len_c;
  logic [MaxNeedle*8-1:0]        aligned;

  logic [CntW-1:0] byte_count, byte_count_next;
  logic            search_done, search_done_next;
  logic            res_found;
  logic [POS_W-1:0] res_pos;
  logic [POS_W-1:0] match_pos;

  logic [7:0]     win [MaxNeedle+1];
  logic [MaxNeedle-1:0] hit;
  logic           accept;
  logic           res_valid, res_f, done_mid, cnt_live, all_hit;
  logic [CntW-1:0] seen, start;
  logic [POS_W-1:0] res_p;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      pat_len     <= '0;
      needle_flat <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_PAT_LEN:      pat_len <= cfg_data[LEN_REG_W-1:0];
        CFG_NEEDLE_0_7:   needle_flat[0*CFG_DATA_W +: CFG_DATA_W] <= cfg_data;
        CFG_NEEDLE_8_15:  needle_flat[1*CFG_DATA_W +: CFG_DATA_W] <= cfg_data;
        CFG_NEEDLE_16_23: needle_flat[2*CFG_DATA_W +: CFG_DATA_W] <= cfg_data;
        CFG_NEEDLE_24_31: needle_flat[3*CFG_DATA_W +: CFG_DATA_W] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if ({1'b0, pat_len} > 7'(MaxNeedle)) begin
      len_c = LenW'(MaxNeedle);
    end else begin
      len_c = LenW'(pat_len);
    end
  end

  csss_needle_align #(
    .MaxNeedle (MaxNeedle)
  ) u_align (
    .needle_flat (needle_flat),
    .len_c       (len_c),
    .aligned     (aligned)
  );

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  // window: cell 0 takes the newest folded byte
  assign win[0] = fold_byte(s_tdata);

  for (genvar i = 0; i < MaxNeedle; i++) begin : g_cell
    cell_ctl_t ctl;
    assign ctl = cell_ctl_t'{shift: accept, active: (LenW'(i) < len_c)};
    csss_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .din      (win[i]),
      .needle_b (aligned[i*8 +: 8]),
      .dout     (win[i+1]),
      .hit      (hit[i])
    );
  end

  assign all_hit  = &hit;
  assign cnt_live = byte_count < CntW'(MaxHaystack);
  assign seen     = byte_count + CntW'(1);
  assign start    = seen - CntW'(len_c);

  always_comb begin
    done_mid        = search_done;
    res_valid       = 1'b0;
    res_f           = 1'b0;
    res_p           = '0;
    if (!search_done) begin
      if (len_c == '0) begin
        res_valid = 1'b1;
        res_f     = 1'b1;
        done_mid  = 1'b1;
      end else if (cnt_live && seen >= CntW'(len_c) && all_hit && (start >> POS_W) == '0) begin
        res_valid = 1'b1;
        res_f     = 1'b1;
        res_p     = POS_W'(start);
        done_mid  = 1'b1;
      end
    end
    byte_count_next  = cnt_live ? seen : byte_count;
    search_done_next = done_mid;
    if (s_tlast) begin
      // end of haystack reports not found unless a match was given
      if (!done_mid) begin
        res_valid = 1'b1;
        res_f     = 1'b0;
        res_p     = '0;
      end
      byte_count_next  = '0;
      search_done_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count  <= '0;
      search_done <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      if (accept) begin
        byte_count  <= byte_count_next;
        search_done <= search_done_next;
      end
      if (accept && res_valid) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res_valid) begin
      res_found <= res_f;
      res_pos   <= res_p;
    end
  end

  assign match_pos = res_pos;
  assign m_tdata   = {7'b0, match_pos, res_found};

endmodule

// ===== rtl/csss_cell.sv =====
// ----------------------------------------------------------------------------
// csss_cell
// One window cell: holds a folded byte, passes it on, compares its input.
// ----------------------------------------------------------------------------
module csss_cell (
  input  logic                clk,
  input  csss_pkg::cell_ctl_t ctl,
  input  logic [7:0]          din,
  input  logic [7:0]          needle_b,
  output logic [7:0]          dout,
  output logic                hit
);
  import csss_pkg::*;

  logic [7:0] w;

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      w <= din;
    end
  end

  assign dout = w;
  // compare against the byte entering this cell, cells past the needle always agree
  assign hit  = !ctl.active || (din == needle_b);

endmodule

// ===== rtl/csss_needle_align.sv =====
// ----------------------------------------------------------------------------
// csss_needle_align
// Folds the needle and lines it up with the window, newest byte first.
// ----------------------------------------------------------------------------
module csss_needle_align #(
  parameter int MaxNeedle = csss_pkg::MAX_NEEDLE_DEF
) (
  input  logic [csss_pkg::NEEDLE_REG_BYTES*8-1:0] needle_flat,
  input  logic [$clog2(MaxNeedle+1)-1:0]          len_c,
  output logic [MaxNeedle*8-1:0]                  aligned
);
  import csss_pkg::*;

  localparam int LenW = $clog2(MaxNeedle+1);

  logic [MaxNeedle*8-1:0] rev;
  logic [LenW-1:0]        sh;

  // rev holds needle byte j at byte place MaxNeedle-1-j
  for (genvar j = 0; j < MaxNeedle; j++) begin : g_rev
    if (j < NEEDLE_REG_BYTES) begin : g_cfg
      assign rev[(MaxNeedle-1-j)*8 +: 8] = fold_byte(needle_flat[j*8 +: 8]);
    end else begin : g_zero
      assign rev[(MaxNeedle-1-j)*8 +: 8] = 8'h00;
    end
  end

  // window cell i wants needle byte len-1-i
  assign sh      = LenW'(MaxNeedle) - len_c;
  assign aligned = rev >> {sh, 3'b000};

endmodule
